// File: rtl/sdcd_pkg.sv
// ----------------------------------------------------------------------------
// sdcd_pkg
// shared constants, types and helper functions of the sensor dump change
// detector
// ----------------------------------------------------------------------------
package sdcd_pkg;

  // number of sensor modules in one dump, two bytes each
  localparam int MODULES     = 5;
  localparam int DUMP_BYTES  = 2 * MODULES;
  localparam int POS_W       = (DUMP_BYTES > 1) ? $clog2(DUMP_BYTES) : 1;

  // fixed result field widths
  localparam int MOD_W       = 3;
  localparam int SNS_W       = 5;
  localparam int BIT_W       = 3;

  // job queue between front and back, depth a power of two so the
  // pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [MOD_W-1:0] mod_t;
  typedef logic [SNS_W-1:0] sns_t;
  typedef logic [BIT_W-1:0] bit_t;

  // one byte with at least one changed sensor
  typedef struct packed {
    mod_t       module_index;
    logic       high_half;
    logic [7:0] fresh;
    logic [7:0] diff;
  } job_t;

  // mirror the bit order of a byte
  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // index of the lowest set bit, zero when none is set
  function automatic bit_t lowest_bit(input logic [7:0] v);
    bit_t idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = bit_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/sdcd_front.sv
// ----------------------------------------------------------------------------
// sdcd_front
// takes dump bytes, compares them with the stored dump and queues the
// bytes that changed
// ----------------------------------------------------------------------------
module sdcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_rx_byte,
  output logic              in_full,
  output logic              q_push,
  output sdcd_pkg::job_t    q_job,
  input  logic              q_full
);

  sdcd_pkg::pos_t pos_r;
  sdcd_pkg::pos_t pos_nxt;
  logic [7:0]     prev_r [sdcd_pkg::DUMP_BYTES];
  logic [7:0]     fresh;
  logic [7:0]     diff;
  logic           accept;
  sdcd_pkg::pos_t mod_full;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign fresh   = sdcd_pkg::reverse8(in_rx_byte);
  assign diff    = fresh ^ prev_r[pos_r];
  assign mod_full = pos_r >> 1;

  always_comb begin
    if (pos_r == sdcd_pkg::pos_t'(sdcd_pkg::DUMP_BYTES - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  // unchanged bytes produce no job
  assign q_push             = accept && (diff != 8'h00);
  assign q_job.module_index = sdcd_pkg::mod_t'(mod_full);
  assign q_job.high_half    = pos_r[0];
  assign q_job.fresh        = fresh;
  assign q_job.diff         = diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < sdcd_pkg::DUMP_BYTES; i++) begin
        prev_r[i] <= 8'h00;
      end
    end else if (accept) begin
      pos_r         <= pos_nxt;
      prev_r[pos_r] <= fresh;
    end
  end

endmodule

// File: rtl/sdcd_queue.sv
// ----------------------------------------------------------------------------
// sdcd_queue
// short job queue that decouples the front from the event sequencer
// ----------------------------------------------------------------------------
module sdcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdcd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output sdcd_pkg::job_t head,
  output logic           empty
);

  sdcd_pkg::job_t              mem_r [sdcd_pkg::QUEUE_DEPTH];
  logic [sdcd_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [sdcd_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [sdcd_pkg::QCNT_W-1:0] count_r;
  logic [sdcd_pkg::QCNT_W-1:0] count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count_r == sdcd_pkg::QCNT_W'(sdcd_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/sdcd_back.sv
// ----------------------------------------------------------------------------
// sdcd_back
// walks the changed bits of one job into a result register, one event per
// cycle while the register is free or being popped
// ----------------------------------------------------------------------------
module sdcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  sdcd_pkg::job_t       q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output sdcd_pkg::mod_t       out_module_index,
  output sdcd_pkg::sns_t       out_sensor_number,
  output logic                 out_now_on,
  output logic                 out_last_event
);

  logic           busy_r;
  logic           busy_nxt;
  sdcd_pkg::job_t job_r;
  logic [7:0]     rem_nxt;
  sdcd_pkg::bit_t sel;
  logic           slot_free;
  logic           emit;
  logic           out_valid_r;
  sdcd_pkg::mod_t mod_r;
  sdcd_pkg::sns_t sns_r;
  logic           on_r;
  logic           last_r;
  sdcd_pkg::sns_t sns_nxt;

  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = !busy_r && !q_empty;
  assign emit      = busy_r && slot_free;
  assign sel       = sdcd_pkg::lowest_bit(job_r.diff);
  assign rem_nxt   = job_r.diff & ~(8'h01 << sel);
  assign sns_nxt   = sdcd_pkg::sns_t'({job_r.high_half, sel}) + 1'b1;

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (emit) begin
      busy_nxt = (rem_nxt != 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end else if (emit) begin
      job_r.diff <= rem_nxt;
    end
    if (emit) begin
      mod_r  <= job_r.module_index;
      sns_r  <= sns_nxt;
      on_r   <= job_r.fresh[sel];
      last_r <= (rem_nxt == 8'h00);
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_module_index  = mod_r;
  assign out_sensor_number = sns_r;
  assign out_now_on        = on_r;
  assign out_last_event    = last_r;

endmodule

// File: rtl/sensor_dump_change_detector_unit.sv
// ----------------------------------------------------------------------------
// sensor_dump_change_detector_unit
// turns a repeating sensor dump into one event per sensor that changed
// ----------------------------------------------------------------------------
//
//   channel   handshake        payload
//   --------  ---------------  ---------------------------------------------
//   in        in_push/in_full  in_rx_byte
//   out       out_empty/out_pop out_module_index, out_sensor_number,
//                              out_now_on, out_last_event
//
// a byte is taken whenever the job queue is not full; the front compares it
// with the stored dump and queues it only if some bit changed
// the event sequencer then emits one event per changed bit and picks up the
// next queued byte only after the last event of the current byte
// in_full rises when the two-entry job queue is full; a held result stalls
// only the sequencer, the front keeps taking bytes until the queue fills
// synchronous reset clears the stored dump and the dump position and empties
// the queue and the result register
//
module sensor_dump_change_detector_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // dump bytes
  input  logic                 in_push,
  input  logic [7:0]           in_rx_byte,
  output logic                 in_full,
  // change events
  output logic                 out_empty,
  input  logic                 out_pop,
  output sdcd_pkg::mod_t       out_module_index,
  output sdcd_pkg::sns_t       out_sensor_number,
  output logic                 out_now_on,
  output logic                 out_last_event
);

  // front to queue
  logic           q_push;
  sdcd_pkg::job_t q_job;
  logic           q_full;
  // queue to sequencer
  logic           q_pop;
  sdcd_pkg::job_t q_head;
  logic           q_empty;

  // bit reversal, compare with stored dump, store update
  sdcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_push     (q_push),
    .q_job      (q_job),
    .q_full     (q_full)
  );

  // bytes with changes wait here for the sequencer
  sdcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // one event per changed bit, lowest sensor first
  sdcd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_module_index  (out_module_index),
    .out_sensor_number (out_sensor_number),
    .out_now_on        (out_now_on),
    .out_last_event    (out_last_event)
  );

endmodule
